/* hdl/itda_pkg.sv */
package itda_pkg;

    localparam int unsigned IN_WIDTH   = 64;
    localparam int unsigned CHAR_WIDTH = 6;

    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 6'd45;

    typedef struct packed {
        logic [IN_WIDTH-1:0] value_bits;
        logic                signed_mode;
    } t_in_beat;

    typedef struct packed {
        logic [CHAR_WIDTH-1:0] ascii_char;
        logic                  last;
    } t_out_beat;

endpackage

/* hdl/itda_dabble.sv */
module itda_dabble #(
    parameter int unsigned VALUE_WIDTH = 64,
    parameter int unsigned DIGITS      = 20
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [VALUE_WIDTH-1:0]  i_mag,
    output logic                    o_done,
    output logic [DIGITS*4-1:0]     o_bcd
);
    localparam int unsigned BCD_W = DIGITS * 4;
    localparam int unsigned CNT_W = $clog2(VALUE_WIDTH);

    logic [VALUE_WIDTH-1:0] r_shift, n_shift;
    logic [BCD_W-1:0]       r_bcd, n_bcd;
    logic [BCD_W-1:0]       adj;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_busy, n_busy;
    logic                   r_done, n_done;

    // add-3 correction on every BCD digit before each shift
    always_comb begin
        for (int k = 0; k < DIGITS; k++) begin
            adj[k*4 +: 4] = (r_bcd[k*4 +: 4] >= 4'd5) ? r_bcd[k*4 +: 4] + 4'd3
                                                       : r_bcd[k*4 +: 4];
        end
    end

    always_comb begin
        n_shift = r_shift;
        n_bcd   = r_bcd;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_shift = i_mag;
            n_bcd   = '0;
            n_cnt   = '0;
            n_busy  = 1'b1;
        end else if (r_busy) begin
            n_bcd   = {adj[BCD_W-2:0], r_shift[VALUE_WIDTH-1]};
            n_shift = {r_shift[VALUE_WIDTH-2:0], 1'b0};
            n_cnt   = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(VALUE_WIDTH - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_bcd   <= n_bcd;
        r_cnt   <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

/* hdl/itda_emit.sv */
module itda_emit #(
    parameter int unsigned DIGITS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIGITS*4-1:0]   i_bcd,
    input  logic                  i_neg,
    output logic                  o_last_fire,
    output logic                  o_valid,
    input  logic                  i_stall,
    output itda_pkg::t_out_beat   o_beat
);
    import itda_pkg::*;

    localparam int unsigned BCD_W = DIGITS * 4;
    localparam int unsigned IDX_W = $clog2(DIGITS);

    logic [BCD_W-1:0] r_bcd, n_bcd;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_lead, n_lead;
    logic             r_neg, n_neg;
    logic             r_busy, n_busy;
    logic             r_vld, n_vld;
    t_out_beat        r_beat, n_beat;
    logic [3:0]       digit;
    logic             is_last;
    logic             slot_free;
    logic             last_fire;

    assign digit     = r_bcd[BCD_W-1 -: 4];
    assign is_last   = (r_idx == IDX_W'(DIGITS - 1));
    assign slot_free = !r_vld || !i_stall;

    always_comb begin
        n_bcd     = r_bcd;
        n_idx     = r_idx;
        n_lead    = r_lead;
        n_neg     = r_neg;
        n_busy    = r_busy;
        n_vld     = r_vld && i_stall;
        n_beat    = r_beat;
        last_fire = 1'b0;
        if (i_start) begin
            n_bcd  = i_bcd;
            n_idx  = '0;
            n_lead = 1'b1;
            n_neg  = i_neg;
            n_busy = 1'b1;
        end else if (r_busy && slot_free) begin
            if (r_neg) begin
                n_neg             = 1'b0;
                n_vld             = 1'b1;
                n_beat.ascii_char = CHAR_MINUS;
                n_beat.last       = 1'b0;
            end else begin
                n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
                n_idx = r_idx + IDX_W'(1);
                // leading zeros are dropped, the units digit always goes out
                if (!(r_lead && digit == 4'd0 && !is_last)) begin
                    n_vld             = 1'b1;
                    n_beat.ascii_char = CHAR_ZERO + {2'b00, digit};
                    n_beat.last       = is_last;
                    n_lead            = 1'b0;
                end
                if (is_last) begin
                    n_busy    = 1'b0;
                    last_fire = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd  <= n_bcd;
        r_idx  <= n_idx;
        r_lead <= n_lead;
        r_beat <= n_beat;
        if (!i_rst_n) begin
            r_neg  <= 1'b0;
            r_busy <= 1'b0;
            r_vld  <= 1'b0;
        end else begin
            r_neg  <= n_neg;
            r_busy <= n_busy;
            r_vld  <= n_vld;
        end
    end

    assign o_last_fire = last_fire;
    assign o_valid     = r_vld;
    assign o_beat      = r_beat;

endmodule

/* hdl/integer_to_decimal_ascii_top.sv */
// Integer to decimal ASCII text converter.
// Input channel (i_in_valid / o_in_stall / i_in_beat): one beat carries a
// value and a signed flag; only the low VALUE_WIDTH bits of the value count.
// Output channel (o_out_valid / i_out_stall / o_out_beat): one beat per
// character, most significant first, '-' ahead of a negative signed value,
// last set on the final digit. Zero gives a single '0'.
// Flow: the magnitude is loaded on accept, then a shift-add-3 converter
// takes one input bit per cycle over all VALUE_WIDTH bits, then the digit
// serializer walks all DIGITS BCD digits at one per cycle while the output
// is not stalled, after a '-' for a negative value. One value is in flight
// at a time; o_in_stall is high from accept until the last character is in
// the output register.
// A stalled output register holds its beat and freezes the serializer; the
// conversion itself does not wait on the receiver.
// Reset (i_rst_n low at a clock edge) drops any value in flight and any
// pending output beat.
module integer_to_decimal_ascii_top #(
    parameter int unsigned VALUE_WIDTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  itda_pkg::t_in_beat   i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output itda_pkg::t_out_beat  o_out_beat
);
    import itda_pkg::*;

    localparam int unsigned DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state                 r_state, n_state;
    logic                   r_neg;
    logic                   accept;
    logic [VALUE_WIDTH-1:0] raw;
    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;
    logic                   dab_done;
    logic [DIGITS*4-1:0]    dab_bcd;
    logic                   last_fire;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign raw        = i_in_beat.value_bits[VALUE_WIDTH-1:0];
    assign neg        = i_in_beat.signed_mode && raw[VALUE_WIDTH-1];
    assign mag        = neg ? (~raw + VALUE_WIDTH'(1)) : raw;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (accept)    n_state = ST_CONV;
            ST_CONV: if (dab_done)  n_state = ST_EMIT;
            ST_EMIT: if (last_fire) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_neg <= neg;
        end
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    itda_dabble #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .DIGITS      (DIGITS)
    ) u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_mag   (mag),
        .o_done  (dab_done),
        .o_bcd   (dab_bcd)
    );

    itda_emit #(
        .DIGITS (DIGITS)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (dab_done),
        .i_bcd       (dab_bcd),
        .i_neg       (r_neg),
        .o_last_fire (last_fire),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_beat      (o_out_beat)
    );

`ifndef SYNTH
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_in_stall)
        else $error("second value accepted while one is in flight");

    a_done_in_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dab_done |-> (r_state == ST_CONV))
        else $error("conversion finished outside the convert phase");

    a_last_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last_fire |-> (r_state == ST_EMIT))
        else $error("final digit produced outside the emit phase");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_beat.ascii_char == CHAR_MINUS ||
                         (o_out_beat.ascii_char >= CHAR_ZERO &&
                          o_out_beat.ascii_char <= CHAR_ZERO + 6'd9)))
        else $error("output character is not a digit or minus");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.ascii_char == CHAR_MINUS) |-> !o_out_beat.last)
        else $error("minus sign marked as last character");
`endif

endmodule
